### rtl/scps_pkg.sv
// ----------------------------------------------------------------------------
// scps_pkg
// Types, codes and constants shared by the conversion poll sequencer.
// ----------------------------------------------------------------------------
package scps_pkg;

	// Sequencer phases
	typedef enum logic [2:0] {
		PH_IDLE      = 3'd0,
		PH_REQUESTED = 3'd1,
		PH_WAITING   = 3'd2,
		PH_READY     = 3'd3,
		PH_ERROR     = 3'd4
	} phase_t;

	// Result status codes
	typedef enum logic [2:0] {
		ST_FRESH    = 3'd0,
		ST_CACHED   = 3'd1,
		ST_STALE    = 3'd2,
		ST_NO_VALUE = 3'd3,
		ST_ABSENT   = 3'd4
	} status_t;

	// Register indexes (byte address / 4)
	localparam logic [1:0] REG_RESOLUTION = 2'd0;
	localparam logic [1:0] REG_OFFSET     = 2'd1;
	localparam logic [1:0] REG_RETRY      = 2'd2;
	localparam logic [1:0] REG_PRESENT    = 2'd3;

	// Register reset values
	localparam logic [3:0] RESOLUTION_RST = 4'd12;
	localparam logic [8:0] OFFSET_RST     = 9'd0;
	localparam logic [3:0] RETRY_RST      = 4'd3;
	localparam logic       PRESENT_RST    = 1'b1;

	// Limits
	localparam logic [31:0]        CACHE_MAX_AGE_MS = 32'd60000;
	localparam logic signed [15:0] TEMP_LOW_COUNTS  = -16'sd880;
	localparam logic signed [15:0] TEMP_HIGH_COUNTS = 16'sd2000;

	// Configuration as seen by the sequencer
	typedef struct packed {
		logic [3:0]        conv_res;
		logic signed [8:0] calibration_offset;
		logic [3:0]        retry_limit;
		logic              sensor_present;
	} cfg_t;

	// One result item
	typedef struct packed {
		logic              value_valid;
		logic signed [12:0] temperature_out;
		status_t           status;
	} result_t;

	// Conversion time for a given resolution
	function automatic logic [31:0] wait_ms(input logic [3:0] res);
		logic [31:0] w;
		unique case (res)
			4'd9:    w = 32'd100;
			4'd10:   w = 32'd200;
			4'd11:   w = 32'd400;
			default: w = 32'd750;
		endcase
		return w;
	endfunction

endpackage

### rtl/scps_apb.sv
// ----------------------------------------------------------------------------
// scps_apb
// APB register file holding the sequencer configuration.
// ----------------------------------------------------------------------------
module scps_apb
	import scps_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	logic       wr_en;
	logic [1:0] reg_idx;
	cfg_t       cfg_q;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.conv_res           <= RESOLUTION_RST;
			cfg_q.calibration_offset <= OFFSET_RST;
			cfg_q.retry_limit        <= RETRY_RST;
			cfg_q.sensor_present     <= PRESENT_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_RESOLUTION: cfg_q.conv_res           <= pwdata[3:0];
				REG_OFFSET:     cfg_q.calibration_offset <= pwdata[8:0];
				REG_RETRY:      cfg_q.retry_limit        <= pwdata[3:0];
				REG_PRESENT:    cfg_q.sensor_present     <= pwdata[0];
			endcase
		end
	end

	// Read mux
	always_comb begin
		unique case (reg_idx)
			REG_RESOLUTION: prdata = {28'd0, cfg_q.conv_res};
			REG_OFFSET:     prdata = {{23{cfg_q.calibration_offset[8]}},
						      cfg_q.calibration_offset};
			REG_RETRY:      prdata = {28'd0, cfg_q.retry_limit};
			REG_PRESENT:    prdata = {31'd0, cfg_q.sensor_present};
		endcase
	end

	assign cfg = cfg_q;

endmodule

### rtl/scps_core.sv
// ----------------------------------------------------------------------------
// scps_core
// Sequencer state and the per-poll next-state and result logic.
// ----------------------------------------------------------------------------
module scps_core
	import scps_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  cfg_t               cfg,
	input  logic [31:0]        now_ms,
	input  logic               request_ok,
	input  logic               read_ok,
	input  logic signed [15:0] raw_temperature,
	output result_t            result
);

	phase_t             phase_q, phase_n;
	logic [31:0]        start_time_q, start_time_n;
	logic [3:0]         retries_q, retries_n, retries_inc;
	logic signed [12:0] cached_temp_q;
	logic [31:0]        cached_time_q;
	logic               cache_valid_q;
	logic               fresh;
	logic               in_range;
	logic signed [12:0] temp_sum;
	logic [31:0]        conv_age;
	logic [31:0]        cache_age;

	assign in_range    = (raw_temperature >= TEMP_LOW_COUNTS) &&
			     (raw_temperature <= TEMP_HIGH_COUNTS);
	assign temp_sum    = raw_temperature[12:0] +
			     {{4{cfg.calibration_offset[8]}}, cfg.calibration_offset};
	assign conv_age    = now_ms - start_time_q;
	assign cache_age   = now_ms - cached_time_q;
	assign retries_inc = retries_q + 4'd1;

	// Phase transitions
	always_comb begin
		phase_n      = phase_q;
		start_time_n = start_time_q;
		retries_n    = retries_q;
		fresh        = 1'b0;
		unique case (phase_q)
			PH_IDLE: begin
				if (request_ok) begin
					phase_n      = PH_REQUESTED;
					start_time_n = now_ms;
					retries_n    = 4'd0;
				end
			end
			PH_REQUESTED: phase_n = PH_WAITING;
			PH_WAITING: begin
				if (conv_age >= wait_ms(cfg.conv_res))
					phase_n = PH_READY;
			end
			PH_READY: begin
				if (read_ok && in_range) begin
					fresh   = 1'b1;
					phase_n = PH_IDLE;
				end else begin
					retries_n = retries_inc;
					phase_n   = (retries_inc < cfg.retry_limit) ? PH_IDLE : PH_ERROR;
				end
			end
			default: begin
				phase_n   = PH_IDLE;
				retries_n = 4'd0;
			end
		endcase
	end

	// Result selection
	always_comb begin
		result.value_valid     = 1'b0;
		result.temperature_out = 13'sd0;
		result.status          = ST_NO_VALUE;
		priority if (!cfg.sensor_present) begin
			result.status = ST_ABSENT;
		end else if (fresh) begin
			result.value_valid     = 1'b1;
			result.temperature_out = temp_sum;
			result.status          = ST_FRESH;
		end else if (cache_valid_q) begin
			if (cache_age < CACHE_MAX_AGE_MS) begin
				result.value_valid     = 1'b1;
				result.temperature_out = cached_temp_q;
				result.status          = ST_CACHED;
			end else begin
				result.status = ST_STALE;
			end
		end
	end

	// State registers; an absent sensor freezes everything
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			start_time_q  <= 32'd0;
			retries_q     <= 4'd0;
			cached_temp_q <= 13'sd0;
			cached_time_q <= 32'd0;
			cache_valid_q <= 1'b0;
		end else if (step && cfg.sensor_present) begin
			phase_q      <= phase_n;
			start_time_q <= start_time_n;
			retries_q    <= retries_n;
			if (fresh) begin
				cached_temp_q <= temp_sum;
				cached_time_q <= now_ms;
				cache_valid_q <= 1'b1;
			end
		end
	end

endmodule

### rtl/sensor_conversion_poll_sequencer.sv
// ----------------------------------------------------------------------------
// sensor_conversion_poll_sequencer
// Poll-driven temperature conversion sequencer with result caching.
// ----------------------------------------------------------------------------
// Pipeline: two register stages (input register, then result register); a
// poll's result is offered on m_tvalid once it moves into the result register.
// Throughput: one poll per cycle while m_tready is high, set by the single
// sequencer update done between the two registers; m_tready low stalls both.
// Reset: arst_n clears the sequencer to idle, empties the cache and both
// stages, and loads the register defaults (12, 0, 3, 1).
module sensor_conversion_poll_sequencer
	import scps_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// polls in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // now_ms[31:0], request_ok[32], read_ok[33],
	                              // raw_temperature[49:34], zero[55:50]
	// results out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // temperature_out[12:0], zero[15:13]
	output logic [3:0]  m_tuser   // value_valid[0], status[3:1]
);

	cfg_t               cfg;
	result_t            result;
	logic               valid_s1;
	logic [31:0]        now_s1;
	logic               req_s1;
	logic               rd_s1;
	logic signed [15:0] raw_s1;
	logic               valid_s2;
	result_t            result_s2;
	logic               adv;

	scps_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Stage 1 moves to the result register when that is free or drained
	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			now_s1 <= s_tdata[31:0];
			req_s1 <= s_tdata[32];
			rd_s1  <= s_tdata[33];
			raw_s1 <= s_tdata[49:34];
		end
	end

	scps_core u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (adv),
		.cfg             (cfg),
		.now_ms          (now_s1),
		.request_ok      (req_s1),
		.read_ok         (rd_s1),
		.raw_temperature (raw_s1),
		.result          (result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {3'd0, result_s2.temperature_out};
	assign m_tuser  = {result_s2.status, result_s2.value_valid};

endmodule
